/* rtl/hcbp_pkg.sv */
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants of the code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOLS      = 256;

    localparam int FUNC_W = 2;
    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int PEND_W = 7;
    localparam int PCNT_W = 3;
    localparam int BYTE_W = 8;
    localparam int PAD_W  = 3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_ENCODE = 2'd1,
        FUNC_FLUSH  = 2'd2
    } t_func;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic [PAD_W-1:0]  pad_bits;
        logic              last;
    } t_out_item;

endpackage

/* rtl/hcbp_in_if.sv */
// ----------------------------------------------------------------------------
// hcbp_in_if
// Input channel: valid/ready handshake carrying one input word.
// ----------------------------------------------------------------------------
interface hcbp_in_if;
    logic               valid;
    logic               ready;
    hcbp_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/hcbp_out_if.sv */
// ----------------------------------------------------------------------------
// hcbp_out_if
// Output channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface hcbp_out_if;
    logic                valid;
    logic                ready;
    hcbp_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/hcbp_ram.sv */
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/huffman_code_bit_packer.sv */
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Table-driven prefix code packer: load, encode and flush words in,
// packed bytes out, MSB first.
// ----------------------------------------------------------------------------
// A new input word is taken every cycle as long as the result buffer can
// take its bytes. The code table is one RAM row per symbol (code and
// length), read in the cycle an encode word is accepted; the word is then
// packed against the pending bits and its bytes (up to four) land in a
// result buffer once that is free, which the byte-wide output drains at
// one word per cycle while the output is ready. An encode that yields
// bytes thus holds the buffer until its last byte is taken; load,
// unused-code and partial-byte encodes do not wait for the buffer.
// Entries never loaded read as unused (length 0) from reset on; no
// clearing pass.
module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN,
    parameter int SYMBOLS      = hcbp_pkg::SYMBOLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcbp_in_if.sink     i_in,
    hcbp_out_if.source  o_out
);

    localparam int LEN_CAP   = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                                 : hcbp_pkg::CODE_W;
    localparam int ACC_W     = LEN_CAP + hcbp_pkg::PEND_W;
    localparam int TOT_W     = $clog2(ACC_W + 1);
    // only whole bytes leave the accumulator
    localparam int MAX_BYTES = ACC_W / hcbp_pkg::BYTE_W;
    localparam int IDX_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int ADDR_W    = $clog2(SYMBOLS);
    localparam int ROW_W     = hcbp_pkg::CODE_W + hcbp_pkg::LEN_W;

    // ---------------- accept stage: table access ----------------
    logic                          in_acc;
    logic                          in_range;
    logic [ADDR_W-1:0]             in_addr;
    logic [hcbp_pkg::LEN_W-1:0]    ld_len;
    logic                          tbl_we;
    logic                          tbl_re;
    logic [ROW_W-1:0]              tbl_rdata;

    logic                          r_s1_valid;
    logic [hcbp_pkg::FUNC_W-1:0]   r_s1_func;
    logic                          r_s1_hit;
    logic [SYMBOLS-1:0]            r_ent_vld;

    assign in_acc   = i_in.valid && i_in.ready;
    assign in_range = {1'b0, i_in.data.symbol} < (hcbp_pkg::SYM_W + 1)'(SYMBOLS);
    assign in_addr  = i_in.data.symbol[ADDR_W-1:0];
    assign ld_len   = (i_in.data.code_length > hcbp_pkg::LEN_W'(LEN_CAP))
                    ? hcbp_pkg::LEN_W'(LEN_CAP) : i_in.data.code_length;
    assign tbl_we   = in_acc && (i_in.data.func == hcbp_pkg::FUNC_LOAD) && in_range;
    assign tbl_re   = in_acc && (i_in.data.func == hcbp_pkg::FUNC_ENCODE);

    hcbp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SYMBOLS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (in_addr),
        .i_wdata ({i_in.data.code_bits, ld_len}),
        .i_re    (tbl_re),
        .i_raddr (in_addr),
        .o_rdata (tbl_rdata)
    );

    // ---------------- pack stage ----------------
    logic [hcbp_pkg::PEND_W-1:0]   r_pend;
    logic [hcbp_pkg::PCNT_W-1:0]   r_pcnt;

    logic [hcbp_pkg::CODE_W-1:0]   rd_code;
    logic [hcbp_pkg::LEN_W-1:0]    clen;
    logic [hcbp_pkg::CODE_W-1:0]   code_m;
    logic [ACC_W-1:0]              acc;
    logic [TOT_W-1:0]              total;
    logic [hcbp_pkg::PCNT_W-1:0]   n_pcnt_enc;
    logic [hcbp_pkg::PEND_W-1:0]   n_pend_enc;
    logic [hcbp_pkg::BYTE_W-1:0]   enc_byte [MAX_BYTES];
    logic [hcbp_pkg::PAD_W-1:0]    fl_pad;
    logic [hcbp_pkg::BYTE_W-1:0]   fl_byte;
    logic                          is_enc;
    logic                          is_flush;
    logic [CNT_W-1:0]              s1_nres;
    logic                          s1_adv;
    logic                          grp_load;

    assign rd_code  = tbl_rdata[ROW_W-1:hcbp_pkg::LEN_W];
    assign is_enc   = r_s1_valid && (r_s1_func == hcbp_pkg::FUNC_ENCODE);
    assign is_flush = r_s1_valid && (r_s1_func == hcbp_pkg::FUNC_FLUSH);
    assign clen     = r_s1_hit ? tbl_rdata[hcbp_pkg::LEN_W-1:0] : '0;
    assign code_m   = rd_code & ~({hcbp_pkg::CODE_W{1'b1}} << clen);
    assign acc      = (ACC_W'(r_pend) << clen) | ACC_W'(code_m);
    assign total    = TOT_W'(r_pcnt) + TOT_W'(clen);
    assign n_pcnt_enc = total[hcbp_pkg::PCNT_W-1:0];
    assign n_pend_enc = hcbp_pkg::PEND_W'(acc)
                      & ~({hcbp_pkg::PEND_W{1'b1}} << n_pcnt_enc);

    // byte k of this code: bits that end 8*(k+1) below the top of acc
    always_comb begin
        for (int k = 0; k < MAX_BYTES; k++) begin
            enc_byte[k] = hcbp_pkg::BYTE_W'(acc >> (total - TOT_W'(8 * (k + 1))));
        end
    end

    assign fl_pad  = hcbp_pkg::PAD_W'(hcbp_pkg::BYTE_W - int'(r_pcnt));
    assign fl_byte = hcbp_pkg::BYTE_W'({1'b0, r_pend} << fl_pad);

    always_comb begin
        s1_nres = '0;
        if (is_enc && (clen != '0)) begin
            s1_nres = CNT_W'(total >> 3);
        end else if (is_flush) begin
            s1_nres = CNT_W'(1);
        end
    end

    // ---------------- result buffer ----------------
    logic [hcbp_pkg::BYTE_W-1:0]   r_grp_byte [MAX_BYTES];
    logic                          r_grp_bvalid;
    logic [hcbp_pkg::PAD_W-1:0]    r_grp_pad;
    logic [IDX_W-1:0]              r_grp_lastidx;
    logic [IDX_W-1:0]              r_grp_idx;
    logic                          r_grp_busy;
    logic                          grp_last;
    logic                          out_pop;
    logic                          grp_free;

    assign grp_last = (r_grp_idx == r_grp_lastidx);
    assign out_pop  = o_out.valid && o_out.ready;
    assign grp_free = !r_grp_busy || (out_pop && grp_last);
    assign s1_adv   = grp_free || (s1_nres == '0);
    assign grp_load = r_s1_valid && s1_adv && (s1_nres != '0);

    assign i_in.ready = !r_s1_valid || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_ent_vld  <= '0;
            r_pend     <= '0;
            r_pcnt     <= '0;
            r_grp_busy <= 1'b0;
            r_grp_idx  <= '0;
        end else begin
            if (tbl_we) begin
                r_ent_vld[in_addr] <= 1'b1;
            end

            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv && is_enc && (clen != '0)) begin
                r_pend <= n_pend_enc;
                r_pcnt <= n_pcnt_enc;
            end else if (s1_adv && is_flush) begin
                r_pend <= '0;
                r_pcnt <= '0;
            end

            if (grp_load) begin
                r_grp_busy <= 1'b1;
                r_grp_idx  <= '0;
            end else if (out_pop) begin
                if (grp_last) begin
                    r_grp_busy <= 1'b0;
                end else begin
                    r_grp_idx <= r_grp_idx + 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_func <= i_in.data.func;
            r_s1_hit  <= in_range && r_ent_vld[in_addr];
        end
        if (grp_load) begin
            r_grp_lastidx <= IDX_W'(s1_nres - 1'b1);
            if (is_flush) begin
                r_grp_byte[0] <= (r_pcnt == '0) ? '0 : fl_byte;
                r_grp_bvalid  <= (r_pcnt != '0);
                r_grp_pad     <= (r_pcnt == '0) ? '0 : fl_pad;
            end else begin
                for (int k = 0; k < MAX_BYTES; k++) begin
                    r_grp_byte[k] <= enc_byte[k];
                end
                r_grp_bvalid <= 1'b1;
                r_grp_pad    <= '0;
            end
        end
    end

    assign o_out.valid           = r_grp_busy;
    assign o_out.data.out_byte   = r_grp_byte[r_grp_idx];
    assign o_out.data.byte_valid = r_grp_bvalid;
    assign o_out.data.pad_bits   = r_grp_pad;
    assign o_out.data.last       = grp_last;

endmodule
